@@ sv/assert_macros.svh @@
// Assertion macros used by the top level of the Playfair block.
// Depends on nothing; each macro expands to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_HOLDS(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");
`define ASSERT_IMPLIES(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication failed");
`else
`define ASSERT_HOLDS(name, clk, rstn, prop)
`define ASSERT_IMPLIES(name, clk, rstn, ante, cons)
`endif
`endif

@@ sv/pfc_pkg.sv @@
// Types, constants and small helper functions of the Playfair block.
// Depends on nothing; used by pfc_square and playfair_digraph_cipher.
package pfc_pkg;

    localparam int SQ_SIDE     = 5;
    localparam int SQ_CELLS    = 25;
    localparam int NUM_LETTERS = 26;

    typedef logic [4:0] letter_t;
    typedef logic [4:0] cell_t;
    typedef logic [2:0] coord_t;

    localparam letter_t IDX_I = 5'd8;
    localparam letter_t IDX_J = 5'd9;
    localparam letter_t IDX_X = 5'd23;
    localparam letter_t LAST_LETTER = 5'd25;
    localparam cell_t   FULL_CELLS  = 5'd25;

    localparam logic [1:0] ACT_KEY_CHAR  = 2'd0;
    localparam logic [1:0] ACT_KEY_END   = 2'd1;
    localparam logic [1:0] ACT_TEXT_CHAR = 2'd2;
    localparam logic [1:0] ACT_TEXT_END  = 2'd3;

    typedef struct packed {
        logic    valid;
        letter_t idx;
    } folded_t;

    typedef struct packed {
        logic    we;
        cell_t   wr_cell;
        letter_t wr_letter;
        logic    lp_re;
        letter_t lp_raddr;
        logic    ks_re;
        cell_t   ks_raddr;
    } sq_ctrl_t;

    function automatic folded_t fold_letter(input logic [7:0] c);
        folded_t     f;
        logic [7:0]  diff;
        diff = 8'd0;
        f.valid = 1'b0;
        if (c >= 8'd97 && c <= 8'd122) begin
            diff = c - 8'd97;
            f.valid = 1'b1;
        end else if (c >= 8'd65 && c <= 8'd90) begin
            diff = c - 8'd65;
            f.valid = 1'b1;
        end
        f.idx = diff[4:0];
        if (f.idx == IDX_J) begin
            f.idx = IDX_I;
        end
        return f;
    endfunction

    function automatic coord_t cell_row(input cell_t c);
        coord_t r;
        if (c < 5'd5) begin
            r = 3'd0;
        end else if (c < 5'd10) begin
            r = 3'd1;
        end else if (c < 5'd15) begin
            r = 3'd2;
        end else if (c < 5'd20) begin
            r = 3'd3;
        end else begin
            r = 3'd4;
        end
        return r;
    endfunction

    function automatic coord_t cell_col(input cell_t c);
        cell_t rem;
        coord_t r;
        r = cell_row(c);
        rem = c - ({2'b00, r} << 2) - {2'b00, r};
        return rem[2:0];
    endfunction

    function automatic cell_t cell_of(input coord_t r, input coord_t c);
        return ({2'b00, r} << 2) + {2'b00, r} + {2'b00, c};
    endfunction

    function automatic coord_t inc5(input coord_t v);
        return (v == 3'd4) ? 3'd0 : v + 3'd1;
    endfunction

    function automatic coord_t dec5(input coord_t v);
        return (v == 3'd0) ? 3'd4 : v - 3'd1;
    endfunction

endpackage

@@ sv/pfc_square.sv @@
// Key square and letter-place memories with one write port and registered reads.
// Depends on pfc_pkg for the control struct and index types.
module pfc_square
    import pfc_pkg::*;
(
    input  logic     aclk,
    input  sq_ctrl_t ctrl,
    output cell_t    lp_rdata,
    output letter_t  ks_rdata
);

    letter_t ks_mem [SQ_CELLS];
    cell_t   lp_mem [NUM_LETTERS];
    cell_t   lp_rdata_reg;
    letter_t ks_rdata_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.we) begin
            ks_mem[ctrl.wr_cell]   <= ctrl.wr_letter;
            lp_mem[ctrl.wr_letter] <= ctrl.wr_cell;
        end
        if (ctrl.lp_re) begin
            lp_rdata_reg <= lp_mem[ctrl.lp_raddr];
        end
        if (ctrl.ks_re) begin
            ks_rdata_reg <= ks_mem[ctrl.ks_raddr];
        end
    end

    assign lp_rdata = lp_rdata_reg;
    assign ks_rdata = ks_rdata_reg;

endmodule

@@ sv/playfair_digraph_cipher.sv @@
// Top level of the Playfair digraph cipher: beat decoding, key fill and pair sequencer.
// Depends on pfc_pkg, pfc_square and assert_macros.svh.
//
// Each input beat that only stores a key letter or a pending text letter is taken
// without leaving idle. A key-end beat walks the 26 letters one per cycle. A beat that
// completes a pair starts the pair sequence: the pair is resolved through one
// letter-place read port and one key-square read port, two reads each, and the two
// letters leave one after the other through the output register. The block holds
// s_tready low while a pair or the key fill is in work. There is no clearing pass;
// only reset starts a new key.
module playfair_digraph_cipher
    import pfc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_in
    input  logic [1:0] s_tuser,   // [1:0] action
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [6:0] out_char, [7] zero
    output logic       m_tlast
);

    `include "assert_macros.svh"

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FILL = 3'd1;
    localparam logic [2:0] S_PA   = 3'd2;
    localparam logic [2:0] S_PB   = 3'd3;
    localparam logic [2:0] S_OC   = 3'd4;
    localparam logic [2:0] S_K1   = 3'd5;
    localparam logic [2:0] S_W1   = 3'd6;
    localparam logic [2:0] S_W2   = 3'd7;

    localparam logic [NUM_LETTERS-1:0] USED_RESET = (NUM_LETTERS)'(1) << IDX_J;

    logic [2:0]             state_reg, state_next;
    logic                   mode_reg;
    logic [NUM_LETTERS-1:0] used_reg, used_next;
    cell_t                  fill_reg, fill_next;
    logic                   key_ready_reg, key_ready_next;
    logic                   pend_valid_reg, pend_valid_next;
    letter_t                pend_letter_reg, pend_letter_next;
    letter_t                walk_reg, walk_next;
    letter_t                a_reg, a_next;
    letter_t                b_reg, b_next;
    coord_t                 r1_reg, r1_next, c1_reg, c1_next;
    coord_t                 r2_reg, r2_next, c2_reg, c2_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [6:0]             m_char_reg, m_char_next;
    logic                   m_tlast_reg, m_tlast_next;

    sq_ctrl_t ctrl;
    cell_t    lp_rdata;
    letter_t  ks_rdata;
    folded_t  fl;
    logic     accept;
    logic     place_en;
    letter_t  place_letter;
    logic     out_free;
    coord_t   r1s, r2s, c1s, c2s;
    cell_t    o1, o2;
    logic [6:0] ks_char;

    pfc_square u_square (
        .aclk     (aclk),
        .ctrl     (ctrl),
        .lp_rdata (lp_rdata),
        .ks_rdata (ks_rdata)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign fl       = fold_letter(s_tdata);
    assign out_free = !m_tvalid_reg || m_tready;
    assign ks_char  = 7'd65 + {2'b00, ks_rdata};

    always_comb begin
        r1s = mode_reg ? dec5(r1_reg) : inc5(r1_reg);
        r2s = mode_reg ? dec5(r2_reg) : inc5(r2_reg);
        c1s = mode_reg ? dec5(c1_reg) : inc5(c1_reg);
        c2s = mode_reg ? dec5(c2_reg) : inc5(c2_reg);
        if (r1_reg == r2_reg) begin
            o1 = cell_of(r1_reg, c1s);
            o2 = cell_of(r2_reg, c2s);
        end else if (c1_reg == c2_reg) begin
            o1 = cell_of(r1s, c1_reg);
            o2 = cell_of(r2s, c2_reg);
        end else begin
            o1 = cell_of(r1_reg, c2_reg);
            o2 = cell_of(r2_reg, c1_reg);
        end
    end

    always_comb begin
        state_next       = state_reg;
        used_next        = used_reg;
        fill_next        = fill_reg;
        key_ready_next   = key_ready_reg;
        pend_valid_next  = pend_valid_reg;
        pend_letter_next = pend_letter_reg;
        walk_next        = walk_reg;
        a_next           = a_reg;
        b_next           = b_reg;
        r1_next          = r1_reg;
        c1_next          = c1_reg;
        r2_next          = r2_reg;
        c2_next          = c2_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_char_next      = m_char_reg;
        m_tlast_next     = m_tlast_reg;
        place_en         = 1'b0;
        place_letter     = fl.idx;
        ctrl.lp_re       = 1'b0;
        ctrl.lp_raddr    = a_reg;
        ctrl.ks_re       = 1'b0;
        ctrl.ks_raddr    = o1;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (s_tuser)
                        ACT_KEY_CHAR: begin
                            place_en = !key_ready_reg && fl.valid;
                        end
                        ACT_KEY_END: begin
                            if (!key_ready_reg) begin
                                walk_next  = '0;
                                state_next = S_FILL;
                            end
                        end
                        ACT_TEXT_CHAR: begin
                            if (key_ready_reg && fl.valid) begin
                                if (!pend_valid_reg) begin
                                    pend_letter_next = fl.idx;
                                    pend_valid_next  = 1'b1;
                                end else begin
                                    a_next     = pend_letter_reg;
                                    state_next = S_PA;
                                    if (!mode_reg && pend_letter_reg == fl.idx) begin
                                        b_next = IDX_X;
                                    end else begin
                                        b_next          = fl.idx;
                                        pend_valid_next = 1'b0;
                                    end
                                end
                            end
                        end
                        default: begin
                            if (key_ready_reg && pend_valid_reg) begin
                                a_next          = pend_letter_reg;
                                b_next          = IDX_X;
                                pend_valid_next = 1'b0;
                                state_next      = S_PA;
                            end
                        end
                    endcase
                end
            end
            S_FILL: begin
                place_en     = 1'b1;
                place_letter = walk_reg;
                walk_next    = walk_reg + 5'd1;
                if (walk_reg == LAST_LETTER) begin
                    key_ready_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            S_PA: begin
                ctrl.lp_re    = 1'b1;
                ctrl.lp_raddr = a_reg;
                state_next    = S_PB;
            end
            S_PB: begin
                r1_next       = cell_row(lp_rdata);
                c1_next       = cell_col(lp_rdata);
                ctrl.lp_re    = 1'b1;
                ctrl.lp_raddr = b_reg;
                state_next    = S_OC;
            end
            S_OC: begin
                r2_next    = cell_row(lp_rdata);
                c2_next    = cell_col(lp_rdata);
                state_next = S_K1;
            end
            S_K1: begin
                ctrl.ks_re    = 1'b1;
                ctrl.ks_raddr = o1;
                state_next    = S_W1;
            end
            S_W1: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_char_next   = ks_char;
                    m_tlast_next  = 1'b0;
                    ctrl.ks_re    = 1'b1;
                    ctrl.ks_raddr = o2;
                    state_next    = S_W2;
                end
            end
            S_W2: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_char_next   = ks_char;
                    m_tlast_next  = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        ctrl.we        = place_en && !used_reg[place_letter] && (fill_reg < FULL_CELLS);
        ctrl.wr_cell   = fill_reg;
        ctrl.wr_letter = place_letter;
        if (ctrl.we) begin
            used_next[place_letter] = 1'b1;
            fill_next               = fill_reg + 5'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            mode_reg        <= 1'b0;
            used_reg        <= USED_RESET;
            fill_reg        <= '0;
            key_ready_reg   <= 1'b0;
            pend_valid_reg  <= 1'b0;
            pend_letter_reg <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            if (cfg_we) begin
                mode_reg <= cfg_wdata;
            end
            used_reg        <= used_next;
            fill_reg        <= fill_next;
            key_ready_reg   <= key_ready_next;
            pend_valid_reg  <= pend_valid_next;
            pend_letter_reg <= pend_letter_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        walk_reg    <= walk_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        r1_reg      <= r1_next;
        c1_reg      <= c1_next;
        r2_reg      <= r2_next;
        c2_reg      <= c2_next;
        m_char_reg  <= m_char_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_char_reg};
    assign m_tlast  = m_tlast_reg;

    // A finished key always fills every cell of the square.
    `ASSERT_IMPLIES(a_key_full, aclk, aresetn, key_ready_reg, fill_reg == FULL_CELLS)
    // Pairs are resolved only against a finished key.
    `ASSERT_IMPLIES(a_pair_keyed, aclk, aresetn, state_reg == S_PA, key_ready_reg)
    // Back in idle, any beat still waiting at the output is the second of its pair.
    `ASSERT_IMPLIES(a_idle_last, aclk, aresetn,
                    state_reg == S_IDLE && m_tvalid_reg, m_tlast_reg)
    // The key becomes ready only at the end of the fill walk.
    `ASSERT_IMPLIES(a_ready_from_fill, aclk, aresetn,
                    $rose(key_ready_reg), $past(state_reg) == S_FILL)

endmodule

@@ test/tb.sv @@
// Self-checking testbench for playfair_digraph_cipher: directed key and text beats, then
// random beat phases in both modes, each result checked against a Playfair model kept here.
// Depends on pfc_pkg and the playfair_digraph_cipher RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pfc_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } cipher_beat_t;

    typedef struct packed {
        logic [1:0] act;
        logic [7:0] ch;
        logic       silent;
        logic       set_mode;
        logic       mode_val;
    } stim_row_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_we = 1'b0;
    logic       cfg_wdata = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic [1:0] s_tuser = 2'b00;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;

    cipher_beat_t cipher_q[$];

    letter_t square[SQ_CELLS];
    cell_t   place[NUM_LETTERS];
    bit      used[NUM_LETTERS];
    int      filled = 0;
    bit      key_done = 1'b0;
    bit      held_v = 1'b0;
    letter_t held = '0;
    bit      dec_mode = 1'b0;

    int          fails = 0;
    int          stall_left = 0;
    bit          tx_idle = 1'b1;
    bit          rx_idle = 1'b1;
    int          prev_letter = 0;
    int unsigned cycle_count = 0;

    stim_row_t dir_rows[26] = '{
        '{ACT_TEXT_CHAR, "A",   1'b1, 1'b0, 1'b0},
        '{ACT_TEXT_END,  8'h00, 1'b1, 1'b0, 1'b0},
        '{ACT_KEY_CHAR,  "p",   1'b1, 1'b0, 1'b0},
        '{ACT_KEY_CHAR,  "L",   1'b1, 1'b0, 1'b0},
        '{ACT_KEY_CHAR,  "a",   1'b1, 1'b0, 1'b0},
        '{ACT_KEY_CHAR,  8'h00, 1'b1, 1'b0, 1'b0},
        '{ACT_KEY_CHAR,  "J",   1'b1, 1'b0, 1'b0},
        '{ACT_KEY_CHAR,  "i",   1'b1, 1'b0, 1'b0},
        '{ACT_KEY_CHAR,  "R",   1'b1, 1'b0, 1'b0},
        '{ACT_KEY_CHAR,  "e",   1'b1, 1'b0, 1'b0},
        '{ACT_KEY_CHAR,  "x",   1'b1, 1'b0, 1'b0},
        '{ACT_KEY_CHAR,  8'hFF, 1'b1, 1'b0, 1'b0},
        '{ACT_KEY_END,   8'h00, 1'b1, 1'b0, 1'b0},
        '{ACT_KEY_CHAR,  "q",   1'b1, 1'b0, 1'b0},
        '{ACT_KEY_END,   8'hFF, 1'b1, 1'b0, 1'b0},
        '{ACT_TEXT_CHAR, "h",   1'b1, 1'b0, 1'b0},
        '{ACT_TEXT_CHAR, "I",   1'b0, 1'b0, 1'b0},
        '{ACT_TEXT_CHAR, "z",   1'b1, 1'b0, 1'b0},
        '{ACT_TEXT_CHAR, "Z",   1'b0, 1'b0, 1'b0},
        '{ACT_TEXT_END,  8'h00, 1'b0, 1'b0, 1'b0},
        '{ACT_TEXT_END,  8'hFF, 1'b1, 1'b0, 1'b0},
        '{ACT_TEXT_CHAR, "x",   1'b1, 1'b0, 1'b0},
        '{ACT_TEXT_CHAR, "X",   1'b0, 1'b0, 1'b0},
        '{ACT_TEXT_CHAR, "a",   1'b0, 1'b1, 1'b1},
        '{ACT_TEXT_CHAR, "a",   1'b1, 1'b0, 1'b0},
        '{ACT_TEXT_CHAR, "A",   1'b0, 1'b0, 1'b0}
    };

    playfair_digraph_cipher uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int fold_byte(logic [7:0] b);
        int k;
        k = -1;
        if (b >= "a" && b <= "z") begin
            k = int'(b) - int'("a");
        end else if (b >= "A" && b <= "Z") begin
            k = int'(b) - int'("A");
        end
        if (k == int'(IDX_J)) begin
            k = int'(IDX_I);
        end
        return k;
    endfunction

    function automatic void place_in_square(int k);
        if (!used[k] && filled < SQ_CELLS) begin
            square[filled] = letter_t'(k);
            place[k] = cell_t'(filled);
            used[k] = 1'b1;
            filled++;
        end
    endfunction

    function automatic void cipher_pair(letter_t a, letter_t b);
        int ra, ca, rb, cb, s, oa, ob;
        ra = int'(place[a]) / SQ_SIDE;
        ca = int'(place[a]) % SQ_SIDE;
        rb = int'(place[b]) / SQ_SIDE;
        cb = int'(place[b]) % SQ_SIDE;
        s = dec_mode ? SQ_SIDE - 1 : 1;
        if (ra == rb) begin
            oa = ra * SQ_SIDE + (ca + s) % SQ_SIDE;
            ob = rb * SQ_SIDE + (cb + s) % SQ_SIDE;
        end else if (ca == cb) begin
            oa = ((ra + s) % SQ_SIDE) * SQ_SIDE + ca;
            ob = ((rb + s) % SQ_SIDE) * SQ_SIDE + cb;
        end else begin
            oa = ra * SQ_SIDE + cb;
            ob = rb * SQ_SIDE + ca;
        end
        cipher_q.push_back('{7'(65 + int'(square[oa])), 1'b0});
        cipher_q.push_back('{7'(65 + int'(square[ob])), 1'b1});
    endfunction

    function automatic int playfair_apply(logic [1:0] act, logic [7:0] b);
        int k, n, i;
        k = fold_byte(b);
        n = cipher_q.size();
        case (act)
            ACT_KEY_CHAR: begin
                if (!key_done && k >= 0) begin
                    place_in_square(k);
                end
            end
            ACT_KEY_END: begin
                if (!key_done) begin
                    for (i = 0; i < NUM_LETTERS; i++) begin
                        place_in_square(i);
                    end
                    key_done = 1'b1;
                    held_v = 1'b0;
                end
            end
            ACT_TEXT_CHAR: begin
                if (key_done && k >= 0) begin
                    if (!held_v) begin
                        held = letter_t'(k);
                        held_v = 1'b1;
                    end else if (!dec_mode && int'(held) == k) begin
                        cipher_pair(held, IDX_X);
                    end else begin
                        held_v = 1'b0;
                        cipher_pair(held, letter_t'(k));
                    end
                end
            end
            default: begin
                if (key_done && held_v) begin
                    held_v = 1'b0;
                    cipher_pair(held, IDX_X);
                end
            end
        endcase
        return cipher_q.size() - n;
    endfunction

    task automatic send_beat(input logic [1:0] act, input logic [7:0] b, output int made);
        if (tx_idle && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        made = playfair_apply(act, b);
        @(negedge aclk);
    endtask

    task automatic drain_bus();
        s_tvalid <= 1'b0;
        while (cipher_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_mode(input logic m);
        cfg_we <= 1'b1;
        cfg_wdata <= m;
        @(posedge aclk);
        dec_mode = m;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic make_item(output logic [1:0] act, output logic [7:0] b, output bit counts);
        int r, k;
        r = $urandom_range(0, 99);
        counts = 1'b0;
        b = 8'($urandom_range(0, 255));
        if (r < 78) begin
            k = ($urandom_range(0, 3) == 0) ? prev_letter : $urandom_range(0, 25);
            prev_letter = k;
            b = 8'(($urandom_range(0, 1) ? 97 : 65) + k);
            act = ACT_TEXT_CHAR;
            counts = 1'b1;
        end else if (r < 86) begin
            act = ACT_TEXT_END;
            counts = 1'b1;
        end else if (r < 94) begin
            act = ACT_TEXT_CHAR;
        end else if (r < 97) begin
            act = ACT_KEY_CHAR;
        end else begin
            act = ACT_KEY_END;
        end
    endtask

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (rx_idle && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 5);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cipher_beat_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (cipher_q.size() == 0) begin
                $error("unexpected beat: out_char %0d, last_of_run %0b", m_tdata[6:0], m_tlast);
                fails++;
            end else begin
                w = cipher_q.pop_front();
                if (m_tdata[6:0] !== w.ch) begin
                    $error("out_char: expected %0d, actual %0d", w.ch, m_tdata[6:0]);
                    fails++;
                end
                if (m_tlast !== w.last) begin
                    $error("last_of_run: expected %0b, actual %0b", w.last, m_tlast);
                    fails++;
                end
                if (m_tdata[7] !== 1'b0) begin
                    $error("m_tdata[7]: expected 0, actual %0b", m_tdata[7]);
                    fails++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("playfair_digraph_cipher verification failed");
            $finish;
        end
    end

    initial begin
        logic [1:0] act;
        logic [7:0] b;
        bit         counts;
        int         made, done, ph, i;
        for (i = 0; i < NUM_LETTERS; i++) begin
            used[i] = (i == int'(IDX_J));
            place[i] = '0;
        end
        for (i = 0; i < SQ_CELLS; i++) begin
            square[i] = '0;
        end
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        write_mode(1'b0);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].set_mode) begin
                drain_bus();
                write_mode(dir_rows[r].mode_val);
            end
            send_beat(dir_rows[r].act, dir_rows[r].ch, made);
            if (dir_rows[r].silent && made != 0) begin
                $error("row %0d: expected no result, model gave %0d", r, made);
                fails++;
            end
        end

        for (ph = 0; ph < 6; ph++) begin
            drain_bus();
            write_mode(ph % 2);
            done = 0;
            while (done < 85) begin
                if (done % 25 == 0) begin
                    tx_idle = (ph < 5) && ($urandom_range(0, 2) != 0);
                    rx_idle = (ph < 5) && ($urandom_range(0, 2) != 0);
                end
                make_item(act, b, counts);
                send_beat(act, b, made);
                if (counts) begin
                    done++;
                end
            end
        end
        drain_bus();

        if (fails == 0) begin
            $display("playfair_digraph_cipher verification clean");
        end else begin
            $display("playfair_digraph_cipher verification failed");
        end
        $finish;
    end

endmodule

@@ playfair_digraph_cipher.f @@
+incdir+sv
sv/pfc_pkg.sv
sv/pfc_square.sv
sv/playfair_digraph_cipher.sv
test/tb.sv
